@@ rtl/core/wsd_pkg.sv @@
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

	localparam int unsigned WSD_QDEPTH = 2;

	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	localparam logic [2:0] ST_PAYLOAD    = 3'd0;
	localparam logic [2:0] ST_EMPTY_CTRL = 3'd1;
	localparam logic [2:0] ST_CLOSE      = 3'd2;
	localparam logic [2:0] ST_LONG_LEN   = 3'd3;
	localparam logic [2:0] ST_BAD_OP     = 3'd4;
	localparam logic [2:0] ST_BAD_BIN    = 3'd5;
	localparam logic [2:0] ST_TOO_LONG   = 3'd6;

	// One classified item passed from the parser to the output side.
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] key;
		logic       kind;
		logic       last;
		logic [2:0] status;
	} cmd_t;

	// Push side of the queue as seen from the parser.
	typedef struct packed {
		logic push;
		cmd_t cmd;
	} push_t;

endpackage

@@ rtl/core/wsd_if.sv @@
// ----------------------------------------------------------------------------
// wsd_if
// Valid/ready channels for link bytes and for deframed results.
// ----------------------------------------------------------------------------
interface wsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink   (input valid, input byte_in, output ready);
endinterface

interface wsd_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_kind;
	logic       last_in_frame;
	logic [2:0] status;

	modport source (output valid, output data_byte, output frame_kind,
		output last_in_frame, output status, input ready);
	modport sink   (input valid, input data_byte, input frame_kind,
		input last_in_frame, input status, output ready);
endinterface

@@ rtl/core/wsd_front.sv @@
// ----------------------------------------------------------------------------
// wsd_front
// Header parser: walks each frame header, checks it and classifies bytes.
// ----------------------------------------------------------------------------
module wsd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         max_payload,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	input  logic                q_full,
	output logic                in_ready,
	output wsd_pkg::push_t      q_push
);
	import wsd_pkg::*;

	typedef enum logic [3:0] {
		PH_HDR0, PH_HDR1, PH_EXT0, PH_EXT1,
		PH_MASK0, PH_MASK1, PH_MASK2, PH_MASK3, PH_DATA
	} phase_t;

	phase_t      phase_q, phase_d;
	logic        final_q;
	logic [3:0]  opcode_q;
	logic        mask_q;
	logic [15:0] len_q;
	logic [31:0] key_q;
	logic [15:0] count_q;
	logic        halted_q, halted_d;
	logic        accept;

	logic [15:0] hd_len;
	logic        hd_empty, is_ping, is_pong;
	logic [2:0]  hd_status;
	logic        hd_emit, hd_halt;
	logic        hd_end;
	logic [16:0] count_inc;
	logic        data_last;
	logic [7:0]  key_byte;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready && !halted_q;

	assign is_ping   = (opcode_q == OP_PING);
	assign is_pong   = (opcode_q == OP_PONG);
	assign count_inc = {1'b0, count_q} + 17'd1;
	assign data_last = (count_inc >= {1'b0, len_q});

	always_comb begin
		unique case (count_q[1:0])
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// Length as it stands when the header ends on this byte.
	always_comb begin
		unique case (phase_q)
			PH_HDR1: hd_len = {9'd0, in_byte[6:0]};
			PH_EXT1: hd_len = {len_q[15:8], in_byte};
			default: hd_len = len_q;
		endcase
	end
	assign hd_empty = (hd_len == 16'd0);

	// End-of-header checks, in order of precedence.
	always_comb begin
		hd_status = ST_PAYLOAD;
		hd_emit   = 1'b0;
		hd_halt   = 1'b0;
		priority if (hd_len > max_payload) begin
			hd_status = ST_TOO_LONG; hd_emit = 1'b1; hd_halt = 1'b1;
		end else if (is_ping || is_pong) begin
			hd_status = ST_EMPTY_CTRL; hd_emit = hd_empty;
		end else if (opcode_q == OP_CLOSE) begin
			hd_status = ST_CLOSE; hd_emit = 1'b1; hd_halt = 1'b1;
		end else if (opcode_q != OP_BINARY) begin
			hd_status = ST_BAD_OP; hd_emit = 1'b1; hd_halt = 1'b1;
		end else if (!final_q || hd_empty) begin
			hd_status = ST_BAD_BIN; hd_emit = 1'b1; hd_halt = 1'b1;
		end else begin
			hd_status = ST_PAYLOAD;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		halted_d    = halted_q;
		q_push.push = 1'b0;
		q_push.cmd  = '0;
		hd_end      = 1'b0;
		if (accept) begin
			unique case (phase_q)
				PH_HDR0: phase_d = PH_HDR1;
				PH_HDR1: begin
					if (in_byte[6:0] == LEN_EXT64) begin
						q_push.push       = 1'b1;
						q_push.cmd.status = ST_LONG_LEN;
						halted_d          = 1'b1;
						phase_d           = PH_HDR0;
					end else if (in_byte[6:0] == LEN_EXT16) begin
						phase_d = PH_EXT0;
					end else if (in_byte[7]) begin
						phase_d = PH_MASK0;
					end else begin
						hd_end = 1'b1;
					end
				end
				PH_EXT0: phase_d = PH_EXT1;
				PH_EXT1: begin
					if (mask_q) begin
						phase_d = PH_MASK0;
					end else begin
						hd_end = 1'b1;
					end
				end
				PH_MASK0: phase_d = PH_MASK1;
				PH_MASK1: phase_d = PH_MASK2;
				PH_MASK2: phase_d = PH_MASK3;
				PH_MASK3: hd_end  = 1'b1;
				PH_DATA: begin
					if (data_last) begin
						phase_d = PH_HDR0;
					end
					q_push.push     = !is_pong;
					q_push.cmd.data = in_byte;
					q_push.cmd.key  = mask_q ? key_byte : 8'd0;
					q_push.cmd.kind = is_ping;
					q_push.cmd.last = data_last;
				end
				default: phase_d = PH_HDR0;
			endcase
			if (hd_end) begin
				q_push.push       = hd_emit;
				q_push.cmd.status = hd_status;
				q_push.cmd.kind   = hd_emit && !hd_halt && is_ping;
				halted_d          = hd_halt;
				phase_d           = (hd_emit || hd_halt) ? PH_HDR0 : PH_DATA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			halted_q <= 1'b0;
			final_q  <= 1'b0;
			opcode_q <= '0;
			mask_q   <= 1'b0;
			len_q    <= '0;
			key_q    <= '0;
			count_q  <= '0;
		end else begin
			phase_q  <= phase_d;
			halted_q <= halted_d;
			if (accept) begin
				unique case (phase_q)
					PH_HDR0: begin
						final_q  <= in_byte[7];
						opcode_q <= in_byte[3:0];
					end
					PH_HDR1: begin
						mask_q  <= in_byte[7];
						len_q   <= hd_len;
						count_q <= '0;
					end
					PH_EXT0: len_q <= {in_byte, 8'd0};
					PH_EXT1: begin
						len_q   <= hd_len;
						count_q <= '0;
					end
					PH_MASK0, PH_MASK1, PH_MASK2, PH_MASK3: begin
						key_q   <= {key_q[23:0], in_byte};
						count_q <= '0;
					end
					PH_DATA: count_q <= count_inc[15:0];
					default: count_q <= count_q;
				endcase
			end
		end
	end

endmodule

@@ rtl/core/wsd_queue.sv @@
// ----------------------------------------------------------------------------
// wsd_queue
// Short FIFO of classified items between parser and output stage.
// ----------------------------------------------------------------------------
module wsd_queue #(
	parameter int unsigned DEPTH = wsd_pkg::WSD_QDEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  wsd_pkg::push_t wr,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output wsd_pkg::cmd_t  rd_cmd
);
	import wsd_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = wr.push && !full;
	assign do_pop  = pop && !empty;
	assign rd_cmd  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/core/wsd_back.sv @@
// ----------------------------------------------------------------------------
// wsd_back
// Output stage: unmasks queued items and holds them in the result register.
// ----------------------------------------------------------------------------
module wsd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  wsd_pkg::cmd_t q_cmd,
	output logic          q_pop,
	output logic          res_valid,
	input  logic          res_ready,
	output logic [7:0]    data_byte,
	output logic          frame_kind,
	output logic          last_in_frame,
	output logic [2:0]    status
);
	import wsd_pkg::*;

	logic       valid_q;
	logic [7:0] data_q;
	logic       kind_q, last_q;
	logic [2:0] status_q;

	// Refill the result register whenever it is empty or being taken.
	assign q_pop = !q_empty && (!valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || res_ready) begin
			valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_q   <= q_cmd.data ^ q_cmd.key;
			kind_q   <= q_cmd.kind;
			last_q   <= q_cmd.last;
			status_q <= q_cmd.status;
		end
	end

	assign res_valid     = valid_q;
	assign data_byte     = data_q;
	assign frame_kind    = kind_q;
	assign last_in_frame = last_q;
	assign status        = status_q;

endmodule

@@ rtl/core/websocket_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Frame parser for a masked websocket-style link byte stream.
// ----------------------------------------------------------------------------
// Takes one link byte per cycle while the queue is not full and gives at most
// one result per byte. A result passes from the header parser into a short
// queue and then through the unmasking output register. The queue lets the
// input keep flowing for up to QDEPTH results while the result side stalls;
// once the queue is full, byte_ch.ready drops. After a terminal status the
// block swallows all further bytes until reset. max_payload may be rewritten
// only while idle.
module websocket_frame_deframer #(
	parameter int unsigned QDEPTH = wsd_pkg::WSD_QDEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata,
	wsd_byte_if.sink      byte_ch,
	wsd_res_if.source     res_ch
);
	import wsd_pkg::*;

	logic [15:0] max_payload_q;
	push_t       push;
	cmd_t        q_cmd;
	logic        q_full, q_empty, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= 16'hFFFF;
		end else if (cfg_we) begin
			max_payload_q <= cfg_wdata;
		end
	end

	wsd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.max_payload (max_payload_q),
		.in_valid    (byte_ch.valid),
		.in_byte     (byte_ch.byte_in),
		.q_full      (q_full),
		.in_ready    (byte_ch.ready),
		.q_push      (push)
	);

	wsd_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.pop    (q_pop),
		.full   (q_full),
		.empty  (q_empty),
		.rd_cmd (q_cmd)
	);

	wsd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_cmd         (q_cmd),
		.q_pop         (q_pop),
		.res_valid     (res_ch.valid),
		.res_ready     (res_ch.ready),
		.data_byte     (res_ch.data_byte),
		.frame_kind    (res_ch.frame_kind),
		.last_in_frame (res_ch.last_in_frame),
		.status        (res_ch.status)
	);

endmodule

@@ rtl/core/wsd_checker.sv @@
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks of the deframer result channel.
// ----------------------------------------------------------------------------
module wsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] data_byte,
	input logic       frame_kind,
	input logic       last_in_frame,
	input logic [2:0] status
);
	import wsd_pkg::*;

	logic terminal;
	assign terminal = (status == ST_CLOSE) || (status == ST_LONG_LEN) ||
		(status == ST_BAD_OP) || (status == ST_BAD_BIN) || (status == ST_TOO_LONG);

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(data_byte) && $stable(status))
		else $error("result changed while stalled");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status != ST_PAYLOAD) |-> (data_byte == 8'd0) && !last_in_frame)
		else $error("status result carries payload fields");

	a_term_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && terminal |-> !frame_kind)
		else $error("terminal status with frame kind set");

	// Nothing may follow a terminal status.
	a_term_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && terminal |=> !res_valid)
		else $error("result after terminal status");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res_ch.valid),
	.res_ready     (res_ch.ready),
	.data_byte     (res_ch.data_byte),
	.frame_kind    (res_ch.frame_kind),
	.last_in_frame (res_ch.last_in_frame),
	.status        (res_ch.status)
);
